// ===== rtl/core/pbrle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder package
// Shared constants and the command and status groups that pass between the
// decoder controller and its datapath.
// ----------------------------------------------------------------------------
package pbrle_pkg;

  localparam int COUNT_BITS_DEF = 24;

  localparam logic [7:0] SKIP_HEADER = 8'h80;
  localparam logic [7:0] PAD_MAX     = 8'd128;

  // Controller to datapath.
  typedef struct packed {
    logic lit_load;   // header opens a literal run
    logic rep_load;   // header opens a repeat run
    logic lit_emit;   // pass one literal byte on
    logic rep_start;  // repeat byte arrived, start emitting pairs
    logic pad_start;  // pad command with bytes missing
    logic pad_empty;  // pad command with nothing missing
    logic run_step;   // emit one word of the current run
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;     // output register can take a word this cycle
    logic reached;      // emitted count has reached the expected length
    logic lit_last;     // the next literal byte closes the run
    logic run_last;     // the next run word is the final one
    logic hdr_literal;  // incoming byte read as a header opens a literal run
    logic hdr_skip;     // incoming byte is the no-op header
  } dp_status_t;

endpackage

// ===== rtl/core/packbits_rle_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Decodes a packed byte stream into words of up to two bytes, with zero
// padding up to a configured length.
// ----------------------------------------------------------------------------
// A header byte, a skipped or dropped header and a literal byte are each
// accepted as input allows; a literal byte leaves as a one-byte word in the
// following cycle. A repeat byte or a pad command is accepted and then emits
// its n bytes as ceil(n/2) words through the single output register, so a
// 128-byte repeat leaves as 64 words before the next input is taken. Input is
// stalled while a run is emitted and while the output register holds a word
// the receiver is stalling. The user must write the expected length through
// cfg_wr_en and cfg_wr_data while the block is idle, which the block does not check.
module packbits_rle_decoder
  import pbrle_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_first_byte,
  output logic [7:0]            out_second_byte,
  output logic [1:0]            out_byte_count,
  output logic                  out_last_of_run,
  output logic                  out_all_done
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pbrle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  pbrle_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_byte_count  (out_byte_count),
    .out_last_of_run (out_last_of_run),
    .out_all_done    (out_all_done)
  );

endmodule

// ===== rtl/core/pbrle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder controller
// Tracks the decode phase, accepts input words and sequences run emission.
// ----------------------------------------------------------------------------
module pbrle_ctrl
  import pbrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_command,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_HEADER  = 2'd0;
  localparam logic [1:0] S_LITERAL = 2'd1;
  localparam logic [1:0] S_REPEAT  = 2'd2;
  localparam logic [1:0] S_EMIT    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r == S_EMIT) || !status.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_EMIT: begin
        if (status.out_free) begin
          cmd.run_step = 1'b1;
          if (status.run_last) begin
            state_nxt = S_HEADER;
          end
        end
      end
      S_LITERAL: begin
        if (accept && !in_command) begin
          cmd.lit_emit = 1'b1;
          if (status.lit_last) begin
            state_nxt = S_HEADER;
          end
        end
      end
      S_REPEAT: begin
        if (accept && !in_command) begin
          cmd.rep_start = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_HEADER: begin
        // Once the expected length is reached, headers are dropped.
        if (accept && !in_command && !status.reached) begin
          if (status.hdr_literal) begin
            cmd.lit_load = 1'b1;
            state_nxt    = S_LITERAL;
          end else if (!status.hdr_skip) begin
            cmd.rep_load = 1'b1;
            state_nxt    = S_REPEAT;
          end
        end
      end
      default: begin
        state_nxt = S_HEADER;
      end
    endcase

    // A pad command abandons any open run.
    if (accept && in_command) begin
      cmd.lit_emit  = 1'b0;
      cmd.rep_start = 1'b0;
      cmd.lit_load  = 1'b0;
      cmd.rep_load  = 1'b0;
      if (status.reached) begin
        cmd.pad_empty = 1'b1;
        state_nxt     = S_HEADER;
      end else begin
        cmd.pad_start = 1'b1;
        state_nxt     = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/pbrle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder datapath
// Holds the run counters, the emitted byte count, the expected length and the
// output register.
// ----------------------------------------------------------------------------
module pbrle_dp
  import pbrle_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_BITS-1:0] cfg_wr_data,
  input  logic [7:0]            in_data_byte,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_first_byte,
  output logic [7:0]            out_second_byte,
  output logic [1:0]            out_byte_count,
  output logic                  out_last_of_run,
  output logic                  out_all_done
);

  localparam int EB = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] expected_r;
  logic [EB-1:0]         emitted_r;
  logic [EB-1:0]         emitted_nxt;
  logic [7:0]            literal_left_r;
  logic [7:0]            repeat_length_r;
  logic [7:0]            rem_r;
  logic [7:0]            run_val_r;

  logic                  out_valid_r;
  logic [7:0]            first_r;
  logic [7:0]            second_r;
  logic [1:0]            count_r;
  logic                  last_r;
  logic                  done_r;

  logic [EB-1:0]         expected_ext;
  logic [EB-1:0]         missing;
  logic [7:0]            pad_n;
  logic                  emit;
  logic [1:0]            emit_cnt;
  logic [7:0]            emit_first;
  logic [7:0]            emit_second;
  logic                  emit_last;
  logic [EB:0]           sum;
  logic                  run_pair;

  assign expected_ext = {1'b0, expected_r};
  assign missing      = expected_ext - emitted_r;
  assign pad_n        = (missing > EB'(PAD_MAX)) ? PAD_MAX : missing[7:0];
  assign run_pair     = (rem_r >= 8'd2);

  assign status.out_free    = !out_valid_r || !out_stall;
  assign status.reached     = (emitted_r >= expected_ext);
  assign status.lit_last    = (literal_left_r <= 8'd1);
  assign status.run_last    = (rem_r <= 8'd2);
  assign status.hdr_literal = !in_data_byte[7];
  assign status.hdr_skip    = (in_data_byte == SKIP_HEADER);

  always_comb begin
    emit        = 1'b0;
    emit_cnt    = 2'd0;
    emit_first  = 8'd0;
    emit_second = 8'd0;
    emit_last   = 1'b1;
    if (cmd.lit_emit) begin
      emit       = 1'b1;
      emit_cnt   = 2'd1;
      emit_first = in_data_byte;
    end else if (cmd.pad_empty) begin
      emit = 1'b1;
    end else if (cmd.run_step) begin
      emit        = 1'b1;
      emit_cnt    = run_pair ? 2'd2 : 2'd1;
      emit_first  = run_val_r;
      emit_second = run_pair ? run_val_r : 8'd0;
      emit_last   = status.run_last;
    end
  end

  // The byte count saturates at all ones rather than wrapping.
  assign sum         = {1'b0, emitted_r} + (EB + 1)'(emit_cnt);
  assign emitted_nxt = sum[EB] ? {EB{1'b1}} : sum[EB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r      <= '0;
      emitted_r       <= '0;
      literal_left_r  <= '0;
      repeat_length_r <= '0;
      rem_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        expected_r <= cfg_wr_data;
      end
      if (emit) begin
        emitted_r <= emitted_nxt;
      end
      if (cmd.lit_load) begin
        literal_left_r <= in_data_byte + 8'd1;
      end else if (cmd.lit_emit) begin
        literal_left_r <= literal_left_r - 8'd1;
      end
      if (cmd.rep_load) begin
        // 257 - b gives the repeat length 1 - h for a negative header h.
        repeat_length_r <= 8'(9'd257 - {1'b0, in_data_byte});
      end
      if (cmd.rep_start) begin
        rem_r <= repeat_length_r;
      end else if (cmd.pad_start) begin
        rem_r <= pad_n;
      end else if (cmd.run_step) begin
        rem_r <= rem_r - (run_pair ? 8'd2 : 8'd1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_start) begin
      run_val_r <= in_data_byte;
    end else if (cmd.pad_start) begin
      run_val_r <= 8'd0;
    end
    if (emit) begin
      first_r  <= emit_first;
      second_r <= emit_second;
      count_r  <= emit_cnt;
      last_r   <= emit_last;
      done_r   <= (emitted_nxt >= expected_ext);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_byte  = first_r;
  assign out_second_byte = second_r;
  assign out_byte_count  = count_r;
  assign out_last_of_run = last_r;
  assign out_all_done    = done_r;

endmodule

// ===== dv/packbits_rle_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder testbench
// Drives packed streams and pad commands into the decoder, and predicts the
// output words from its own decoding model, save where a directed row gives its
// word. Each word taken from the block is compared with the oldest predicted
// one. A directed table comes first, then random well-formed runs mixed with
// noise under several expected lengths. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module packbits_rle_decoder_test;
  import pbrle_pkg::*;

  localparam int CNT_W      = COUNT_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] nbytes;
    logic       run_end;
    logic       done;
  } word_t;

  typedef enum logic [1:0] {AWAIT_HEADER, IN_LITERAL, AWAIT_REPEAT} dec_phase_e;
  typedef enum logic [1:0] {ROW_CFG, ROW_DATA, ROW_PAD} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CNT_W-1:0] value;
    logic             typed;
    word_t            want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_STEPS [0:23] = '{
    '{ROW_PAD,  24'h0,      1'b1, '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1}},
    '{ROW_DATA, 24'h05,     1'b0, '0},
    '{ROW_CFG,  24'hFFFFFF, 1'b0, '0},
    '{ROW_DATA, 24'h00,     1'b0, '0},
    '{ROW_DATA, 24'hFF,     1'b1, '{8'hFF, 8'h00, 2'd1, 1'b1, 1'b0}},
    '{ROW_DATA, 24'h7F,     1'b0, '0},
    '{ROW_DATA, 24'h00,     1'b1, '{8'h00, 8'h00, 2'd1, 1'b1, 1'b0}},
    '{ROW_DATA, 24'hAA,     1'b0, '0},
    '{ROW_PAD,  24'h0,      1'b0, '0},
    '{ROW_DATA, 24'h80,     1'b0, '0},
    '{ROW_DATA, 24'h81,     1'b0, '0},
    '{ROW_DATA, 24'h5A,     1'b0, '0},
    '{ROW_DATA, 24'hFF,     1'b0, '0},
    '{ROW_DATA, 24'h00,     1'b1, '{8'h00, 8'h00, 2'd2, 1'b1, 1'b0}},
    '{ROW_DATA, 24'hFE,     1'b0, '0},
    '{ROW_DATA, 24'h33,     1'b0, '0},
    '{ROW_DATA, 24'hC0,     1'b0, '0},
    '{ROW_PAD,  24'h0,      1'b0, '0},
    '{ROW_CFG,  24'd5,      1'b0, '0},
    '{ROW_DATA, 24'h01,     1'b0, '0},
    '{ROW_DATA, 24'h7F,     1'b0, '0},
    '{ROW_PAD,  24'h0,      1'b1, '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1}},
    '{ROW_CFG,  24'd0,      1'b0, '0},
    '{ROW_PAD,  24'h0,      1'b1, '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1}}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_command;
  logic [7:0]       in_data_byte;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_first_byte;
  logic [7:0]       out_second_byte;
  logic [1:0]       out_byte_count;
  logic             out_last_of_run;
  logic             out_all_done;

  // Decoder state as the testbench predicts it.
  dec_phase_e       dec_phase = AWAIT_HEADER;
  logic [7:0]       lit_left  = '0;
  logic [7:0]       rep_len   = '0;
  logic [CNT_W:0]   emitted   = '0;
  logic [CNT_W-1:0] want_len  = '0;

  word_t       pending_words[$];
  word_t       fresh_words[$];
  int unsigned sent_items    = 0;
  int unsigned errors        = 0;
  int unsigned idle_cycles   = 0;
  bit          send_steady   = 1'b0;
  bit          recv_steady   = 1'b0;

  packbits_rle_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_byte_count  (out_byte_count),
    .out_last_of_run (out_last_of_run),
    .out_all_done    (out_all_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void emit_word(logic [7:0] b0, logic [7:0] b1, logic [1:0] n,
                                    logic run_end);
    logic [CNT_W+1:0] sum;
    word_t            w;
    sum = {1'b0, emitted} + (CNT_W + 2)'(n);
    // The byte counter sticks at all ones rather than wrapping.
    if (sum > {1'b0, {(CNT_W + 1){1'b1}}}) emitted = '1;
    else emitted = sum[CNT_W:0];
    w = '{b0, b1, n, run_end, emitted >= want_len};
    fresh_words = {fresh_words, w};
  endfunction

  function automatic void emit_run(logic [7:0] v, logic [7:0] n);
    logic [7:0] left;
    logic [1:0] c;
    left = n;
    while (left != 0) begin
      c = (left >= 8'd2) ? 2'd2 : 2'd1;
      left = left - {6'd0, c};
      emit_word(v, (c == 2'd2) ? v : 8'h00, c, left == 0);
    end
  endfunction

  // Advances the predicted decoder by one item and queues the words it causes.
  function automatic void decode_word(logic cmd, logic [7:0] data);
    logic [CNT_W:0] missing;
    logic [7:0]     n;
    if (cmd) begin
      dec_phase = AWAIT_HEADER;
      lit_left  = '0;
      rep_len   = '0;
      missing   = (emitted < want_len) ? want_len - emitted : '0;
      n = (missing > PAD_MAX) ? PAD_MAX : missing[7:0];
      if (n == 0) emit_word(8'h00, 8'h00, 2'd0, 1'b1);
      else emit_run(8'h00, n);
      return;
    end
    case (dec_phase)
      IN_LITERAL: begin
        if (lit_left != 0) lit_left = lit_left - 8'd1;
        if (lit_left == 0) dec_phase = AWAIT_HEADER;
        emit_word(data, 8'h00, 2'd1, 1'b1);
      end
      AWAIT_REPEAT: begin
        n = rep_len;
        dec_phase = AWAIT_HEADER;
        rep_len = '0;
        if (n != 0) emit_run(data, n);
      end
      default: begin
        dec_phase = AWAIT_HEADER;
        // Headers are dropped once the expected length is reached.
        if (emitted >= want_len) return;
        if (data < 8'h80) begin
          lit_left  = data + 8'd1;
          dec_phase = IN_LITERAL;
        end else if (data != SKIP_HEADER) begin
          rep_len   = 8'(9'd257 - {1'b0, data});
          dec_phase = AWAIT_REPEAT;
        end
      end
    endcase
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_word(input logic cmd, input logic [7:0] data, input logic typed,
                           input word_t want);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    decode_word(cmd, data);
    sent_items++;
    if (typed) begin
      fresh_words = {want};
    end
    pending_words = {pending_words, fresh_words};
    fresh_words.delete();
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] len);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    want_len     = len;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      len;
    int unsigned      pick;
    logic [CNT_W+1:0] target;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_command   = 1'b0;
    in_data_byte = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == ROW_CFG) begin
        write_length(DIRECTED_STEPS[i].value);
      end else begin
        send_word(DIRECTED_STEPS[i].kind == ROW_PAD, DIRECTED_STEPS[i].value[7:0],
                  DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
      end
    end

    while (sent_items < 180) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        target = '0;
      end else if (pick == 1) begin
        target = (CNT_W + 2)'({CNT_W{1'b1}});
      end else if (pick == 2) begin
        target = (CNT_W + 2)'($urandom_range(0, (1 << CNT_W) - 1));
      end else begin
        // Mostly a little beyond what has been produced, so that runs overshoot.
        target = {1'b0, emitted} + (CNT_W + 2)'($urandom_range(1, 300));
        if (target > (CNT_W + 2)'({CNT_W{1'b1}})) target = (CNT_W + 2)'({CNT_W{1'b1}});
      end
      write_length(target[CNT_W-1:0]);

      repeat ($urandom_range(3, 8)) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          send_word(1'b0, len[7:0], 1'b0, '0);
          repeat (len + 1) send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 15) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(129, 255)
                                             : $urandom_range(248, 255);
          send_word(1'b0, len[7:0], 1'b0, '0);
          send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick == 15) begin
          send_word(1'b0, SKIP_HEADER, 1'b0, '0);
        end else if (pick == 16) begin
          send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick == 17) begin
          settle();
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)), 1'b0, '0);
          end
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("[packbits_rle_decoder] OK");
    end else begin
      $display("[packbits_rle_decoder] ERROR");
    end
    $finish;
  end

  // The receiver stalls for a random number of cycles before taking each word.
  initial begin : receiver
    int unsigned wait_cycles;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
      wait_cycles = recv_steady ? 0 : $urandom_range(0, 11);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_words
    word_t got;
    word_t w;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("[packbits_rle_decoder] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_first_byte, out_second_byte, out_byte_count, out_last_of_run,
                out_all_done};
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got %h %h n=%0d end=%b done=%b",
                   $realtime, got.b0, got.b1, got.nbytes, got.run_end, got.done);
        end else begin
          w = pending_words.pop_front();
          if (got.b0 !== w.b0 || got.b1 !== w.b1 || got.nbytes !== w.nbytes ||
              got.run_end !== w.run_end || got.done !== w.done) begin
            errors++;
            $display("%0t: word mismatch, expected %h %h n=%0d end=%b done=%b,",
                     $realtime, w.b0, w.b1, w.nbytes, w.run_end, w.done,
                     " got %h %h n=%0d end=%b done=%b",
                     got.b0, got.b1, got.nbytes, got.run_end, got.done);
          end
        end
      end
    end
  end

endmodule
